@@ rtl/turtle_vector_step_macros.svh @@
// Assertion macros shared by the turtle vector step RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef TURTLE_VECTOR_STEP_MACROS_SVH
`define TURTLE_VECTOR_STEP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TVS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("turtle_vector_step: check failed");

// Next-cycle implication, disabled while reset is asserted
`define TVS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("turtle_vector_step: check failed");

`endif

@@ rtl/tvs_pkg.sv @@
// Package for the turtle vector step block: number formats, command codes,
// microcode types, the microcode ROM and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tvs_pkg;

  // Number formats
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_FRAC   = 24;
  localparam int TRIG_FRAC    = 30;
  localparam int HEAD_W       = FRAC_BITS + 9;
  localparam int Z_W          = 36;
  localparam int XY_W         = 34;
  localparam int DIST_W       = 33;
  localparam int PROD_W       = DIST_W + XY_W;
  localparam int SCL_W        = PROD_W - TRIG_FRAC;
  localparam int SUM_W        = SCL_W + 1;
  localparam int RED_W        = 36;
  localparam int ATAN_IDX_W   = 5;

  // Heading reduction: offset makes the sum non-negative, then MOD_SH+1 restoring steps
  localparam int MOD_SH  = (FRAC_BITS >= 23) ? 1 : 24 - FRAC_BITS;
  localparam int CNT_MAX = (CORDIC_STEPS - 1 > MOD_SH) ? CORDIC_STEPS - 1 : MOD_SH;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [RED_W-1:0] FULL_TURN  = RED_W'(64'd360 << FRAC_BITS);
  localparam logic [RED_W-1:0] MOD_OFFSET = RED_W'((64'd360 << FRAC_BITS) << MOD_SH);

  localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(64'd180 << ANGLE_FRAC);
  localparam logic signed [Z_W-1:0] FULL_ANGLE   = Z_W'(64'd360 << ANGLE_FRAC);
  localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'd90 << ANGLE_FRAC);
  localparam logic signed [XY_W-1:0] INV_GAIN    = XY_W'(64'd652032874);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (TRIG_FRAC - 1));

  localparam logic [63:0] START_RAW   = 64'd300 << FRAC_BITS;
  localparam logic [31:0] POS_RESET   = (START_RAW > 64'h7fff_ffff) ? 32'h7fff_ffff
                                                                   : START_RAW[31:0];
  localparam logic [31:0] WIDTH_RESET = 32'(64'd1 << FRAC_BITS);

  // Command codes
  typedef enum logic [2:0] {
    FN_FORWARD  = 3'd0,
    FN_BACKWARD = 3'd1,
    FN_RIGHT    = 3'd2,
    FN_LEFT     = 3'd3,
    FN_PEN_UP   = 3'd4,
    FN_PEN_DOWN = 3'd5,
    FN_COLOR    = 3'd6,
    FN_WIDTH    = 3'd7
  } func_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CORD_INIT,
    OP_CORD_STEP,
    OP_MUL_X,
    OP_ADD_X,
    OP_MUL_Y,
    OP_ADD_Y,
    OP_EMIT,
    OP_TURN_INIT,
    OP_MOD_STEP,
    OP_HEAD_WR,
    OP_PEN_UP,
    OP_PEN_DOWN,
    OP_SET_COLOR,
    OP_SET_WIDTH
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_DISPATCH,
    COND_CORD_MORE,
    COND_MOD_MORE,
    COND_OUT_BUSY
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MOVE      = PC_W'(1);
  localparam logic [PC_W-1:0] PC_CORD_LOOP = PC_W'(2);
  localparam logic [PC_W-1:0] PC_MUL_X     = PC_W'(3);
  localparam logic [PC_W-1:0] PC_ADD_X     = PC_W'(4);
  localparam logic [PC_W-1:0] PC_MUL_Y     = PC_W'(5);
  localparam logic [PC_W-1:0] PC_ADD_Y     = PC_W'(6);
  localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(7);
  localparam logic [PC_W-1:0] PC_TURN      = PC_W'(8);
  localparam logic [PC_W-1:0] PC_MOD_LOOP  = PC_W'(9);
  localparam logic [PC_W-1:0] PC_HEAD_WR   = PC_W'(10);
  localparam logic [PC_W-1:0] PC_PEN_UP    = PC_W'(11);
  localparam logic [PC_W-1:0] PC_PEN_DOWN  = PC_W'(12);
  localparam logic [PC_W-1:0] PC_COLOR     = PC_W'(13);
  localparam logic [PC_W-1:0] PC_WIDTH     = PC_W'(14);
  localparam logic [PC_W-1:0] PC_LAST      = PC_WIDTH;

  // Microcode ROM
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{OP_IDLE, COND_NONE, PC_IDLE, 1'b1};
    case (pc)
      PC_IDLE:      w = '{OP_IDLE,      COND_DISPATCH,  PC_IDLE,      1'b0};
      PC_MOVE:      w = '{OP_CORD_INIT, COND_NONE,      PC_IDLE,      1'b0};
      PC_CORD_LOOP: w = '{OP_CORD_STEP, COND_CORD_MORE, PC_CORD_LOOP, 1'b0};
      PC_MUL_X:     w = '{OP_MUL_X,     COND_NONE,      PC_IDLE,      1'b0};
      PC_ADD_X:     w = '{OP_ADD_X,     COND_NONE,      PC_IDLE,      1'b0};
      PC_MUL_Y:     w = '{OP_MUL_Y,     COND_NONE,      PC_IDLE,      1'b0};
      PC_ADD_Y:     w = '{OP_ADD_Y,     COND_NONE,      PC_IDLE,      1'b0};
      PC_EMIT:      w = '{OP_EMIT,      COND_OUT_BUSY,  PC_EMIT,      1'b1};
      PC_TURN:      w = '{OP_TURN_INIT, COND_NONE,      PC_IDLE,      1'b0};
      PC_MOD_LOOP:  w = '{OP_MOD_STEP,  COND_MOD_MORE,  PC_MOD_LOOP,  1'b0};
      PC_HEAD_WR:   w = '{OP_HEAD_WR,   COND_NONE,      PC_IDLE,      1'b1};
      PC_PEN_UP:    w = '{OP_PEN_UP,    COND_NONE,      PC_IDLE,      1'b1};
      PC_PEN_DOWN:  w = '{OP_PEN_DOWN,  COND_NONE,      PC_IDLE,      1'b1};
      PC_COLOR:     w = '{OP_SET_COLOR, COND_NONE,      PC_IDLE,      1'b1};
      PC_WIDTH:     w = '{OP_SET_WIDTH, COND_NONE,      PC_IDLE,      1'b1};
      default:      w = '{OP_IDLE,      COND_NONE,      PC_IDLE,      1'b1};
    endcase
    return w;
  endfunction

  // Entry point of each command's routine
  function automatic logic [PC_W-1:0] dispatch(input func_t f);
    logic [PC_W-1:0] pc;
    pc = PC_IDLE;
    case (f)
      FN_FORWARD, FN_BACKWARD: pc = PC_MOVE;
      FN_RIGHT, FN_LEFT:       pc = PC_TURN;
      FN_PEN_UP:               pc = PC_PEN_UP;
      FN_PEN_DOWN:             pc = PC_PEN_DOWN;
      FN_COLOR:                pc = PC_COLOR;
      FN_WIDTH:                pc = PC_WIDTH;
      default:                 pc = PC_IDLE;
    endcase
    return pc;
  endfunction

  // atan(2^-i) in degrees, ANGLE_FRAC fraction bits
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd754974720;
      5'd1:    v = 32'd445687602;
      5'd2:    v = 32'd235489088;
      5'd3:    v = 32'd119537938;
      5'd4:    v = 32'd60000934;
      5'd5:    v = 32'd30029717;
      5'd6:    v = 32'd15018523;
      5'd7:    v = 32'd7509720;
      5'd8:    v = 32'd3754917;
      5'd9:    v = 32'd1877466;
      5'd10:   v = 32'd938734;
      5'd11:   v = 32'd469367;
      5'd12:   v = 32'd234684;
      5'd13:   v = 32'd117342;
      5'd14:   v = 32'd58671;
      5'd15:   v = 32'd29335;
      5'd16:   v = 32'd14668;
      5'd17:   v = 32'd7334;
      5'd18:   v = 32'd3667;
      5'd19:   v = 32'd1833;
      5'd20:   v = 32'd917;
      5'd21:   v = 32'd458;
      5'd22:   v = 32'd229;
      5'd23:   v = 32'd115;
      default: v = 32'd0;
    endcase
    return Z_W'(v);
  endfunction

  // Clamp a wide signed sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [31:0] r;
    if ((&v[SUM_W-1:31]) || !(|v[SUM_W-1:31])) begin
      r = v[31:0];
    end else if (v[SUM_W-1]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/turtle_vector_step.sv @@
// Turtle vector step: turtle command engine that emits line segments.
// Uses tvs_pkg (formats, microcode ROM, atan table) and
// turtle_vector_step_macros.svh (assertion macros).
//
//  Channel | Ports                                     | Moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_func, in_amount,   | one turtle command
//          | in_color_index                            |
//  out     | out_valid, out_ready, out_seg_*           | one segment per pen-down move
//
// A move runs dispatch, CORDIC setup, CORDIC_STEPS passes through the single
// shift-add stage, two multiply steps on the one multiplier, two add steps and emit.
// A turn runs the MOD_SH+1 restoring steps of the heading reduction; pen, color and
// width commands run dispatch and their update. One command is in flight at a time.
// A pen-down move waits in its emit step while the previous segment is not taken.
// Reset (rst_n low, synchronous) puts the turtle at (300, 300), heading 0, pen down.
`timescale 1ns / 1ps
`default_nettype none

`include "turtle_vector_step_macros.svh"

module turtle_vector_step
  import tvs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic signed [31:0] in_amount,
  input  wire logic [7:0]         in_color_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_seg_x_start,
  output logic signed [31:0]      out_seg_y_start,
  output logic signed [31:0]      out_seg_x_end,
  output logic signed [31:0]      out_seg_y_end,
  output logic [7:0]              out_seg_color,
  output logic signed [31:0]      out_seg_width
);

  // Sequencer
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0] cnt_r;
  ctrl_t            ctl;
  logic             jump;
  logic             in_fire;
  logic             out_free;
  logic             emit_wait;

  // Latched command
  func_t              func_r;
  logic signed [31:0] amt_r;
  logic [7:0]         col_in_r;

  // Turtle state
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [HEAD_W-1:0]  head_r;
  logic               pen_r;
  logic [7:0]         color_r;
  logic signed [31:0] thick_r;

  // Datapath registers
  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic                     flip_r;
  logic signed [DIST_W-1:0] dist_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]       nx_r, ny_r;
  logic [RED_W-1:0]         red_r;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] seg_xs_r, seg_ys_r, seg_xe_r, seg_ye_r, seg_w_r;
  logic [7:0]         seg_c_r;

  // Datapath combinational nets
  logic signed [Z_W-1:0]    z_raw, z_wrap, z_fold, at;
  logic                     flip_init;
  logic signed [XY_W-1:0]   xs, ys, sin_sel, cos_sel, mul_in;
  logic signed [DIST_W-1:0] amt_ext, dist_init;
  logic signed [PROD_W-1:0] prod_w, prod_rnd;
  logic signed [SCL_W-1:0]  scaled;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [RED_W-1:0]  turn_delta;
  logic [RED_W-1:0]         red_init, mod_cmp;

  assign ctl       = ucode(pc_r);
  assign in_ready  = (pc_r == PC_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_wait = pen_r && !out_free;

  // Select the next control word
  always_comb begin
    jump = 1'b0;
    case (ctl.cond)
      COND_CORD_MORE: jump = (cnt_r != CNT_W'(CORDIC_STEPS - 1));
      COND_MOD_MORE:  jump = (cnt_r != '0);
      COND_OUT_BUSY:  jump = emit_wait;
      default:        jump = 1'b0;
    endcase
    if (ctl.cond == COND_DISPATCH) begin
      pc_nxt = in_fire ? dispatch(func_t'(in_func)) : pc_r;
    end else if (jump) begin
      pc_nxt = ctl.target;
    end else if (ctl.fin) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // Map heading to the CORDIC range, fold the outer half-plane
  always_comb begin
    z_raw     = Z_W'(head_r) << (ANGLE_FRAC - FRAC_BITS);
    z_wrap    = (z_raw >= HALF_TURN) ? z_raw - FULL_ANGLE : z_raw;
    flip_init = 1'b0;
    z_fold    = z_wrap;
    if (z_wrap > QUARTER_TURN) begin
      z_fold    = z_wrap - HALF_TURN;
      flip_init = 1'b1;
    end else if (z_wrap < -QUARTER_TURN) begin
      z_fold    = z_wrap + HALF_TURN;
      flip_init = 1'b1;
    end
  end

  // CORDIC shift-add terms
  assign xs = x_r >>> cnt_r;
  assign ys = y_r >>> cnt_r;
  assign at = atan_deg(ATAN_IDX_W'(cnt_r));

  // Distance, negated for a backward move
  assign amt_ext   = DIST_W'(amt_r);
  assign dist_init = (func_r == FN_BACKWARD) ? -amt_ext : amt_ext;

  // Shared multiplier and rounding
  assign sin_sel  = flip_r ? -y_r : y_r;
  assign cos_sel  = flip_r ? -x_r : x_r;
  assign mul_in   = (ctl.op == OP_MUL_X) ? sin_sel : cos_sel;
  assign prod_w   = PROD_W'(dist_r) * PROD_W'(mul_in);
  assign prod_rnd = prod_r + ROUND_HALF;
  assign scaled   = prod_rnd[PROD_W-1:TRIG_FRAC];
  assign sum_x    = SUM_W'(pos_x_r) + SUM_W'(scaled);
  assign sum_y    = SUM_W'(pos_y_r) - SUM_W'(scaled);

  // Heading reduction terms
  assign turn_delta = (func_r == FN_LEFT) ? -RED_W'(amt_r) : RED_W'(amt_r);
  assign red_init   = RED_W'(head_r) + turn_delta + MOD_OFFSET;
  assign mod_cmp    = FULL_TURN << cnt_r;

  // Hold the segment until taken, load it when a pen-down move finishes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.op == OP_EMIT && pen_r && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and turtle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= POS_RESET;
      pos_y_r     <= POS_RESET;
      head_r      <= '0;
      pen_r       <= 1'b1;
      color_r     <= '0;
      thick_r     <= WIDTH_RESET;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      case (ctl.op)
        OP_CORD_INIT: cnt_r <= '0;
        OP_CORD_STEP: cnt_r <= cnt_r + CNT_W'(1);
        OP_TURN_INIT: cnt_r <= CNT_W'(MOD_SH);
        OP_MOD_STEP:  cnt_r <= cnt_r - CNT_W'(1);
        OP_HEAD_WR:   head_r <= red_r[HEAD_W-1:0];
        OP_PEN_UP:    pen_r <= 1'b0;
        OP_PEN_DOWN:  pen_r <= 1'b1;
        OP_SET_COLOR: color_r <= col_in_r;
        OP_SET_WIDTH: thick_r <= amt_r;
        OP_EMIT: begin
          if (!emit_wait) begin
            pos_x_r <= nx_r;
            pos_y_r <= ny_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r   <= func_t'(in_func);
      amt_r    <= in_amount;
      col_in_r <= in_color_index;
    end
    case (ctl.op)
      OP_CORD_INIT: begin
        x_r    <= INV_GAIN;
        y_r    <= '0;
        z_r    <= z_fold;
        flip_r <= flip_init;
        dist_r <= dist_init;
      end
      OP_CORD_STEP: begin
        if (!z_r[Z_W-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end
      end
      OP_MUL_X, OP_MUL_Y: prod_r <= prod_w;
      OP_ADD_X: nx_r <= sat32(sum_x);
      OP_ADD_Y: ny_r <= sat32(sum_y);
      OP_TURN_INIT: red_r <= red_init;
      OP_MOD_STEP: begin
        if (red_r >= mod_cmp) begin
          red_r <= red_r - mod_cmp;
        end
      end
      OP_EMIT: begin
        if (pen_r && out_free) begin
          seg_xs_r <= pos_x_r;
          seg_ys_r <= pos_y_r;
          seg_xe_r <= nx_r;
          seg_ye_r <= ny_r;
          seg_c_r  <= color_r;
          seg_w_r  <= thick_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_seg_x_start = seg_xs_r;
  assign out_seg_y_start = seg_ys_r;
  assign out_seg_x_end   = seg_xe_r;
  assign out_seg_y_end   = seg_ye_r;
  assign out_seg_color   = seg_c_r;
  assign out_seg_width   = seg_w_r;

  // Checks
  `TVS_ASSERT_NOW(a_head_range, 1'b1, RED_W'(head_r) < FULL_TURN)
  `TVS_ASSERT_NOW(a_pc_range, 1'b1, pc_r <= PC_LAST)
  `TVS_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, pc_r != PC_IDLE)
  `TVS_ASSERT_NEXT(a_load_only_at_emit, !out_valid_r && ctl.op != OP_EMIT, !out_valid_r)

endmodule

`default_nettype wire
